// File: rtl/core/gcta_pkg.sv
// shared types and constants for the greedy contention task assigner
`default_nettype none
package gcta_pkg;
    localparam int CostW = 32;
    localparam int IdxW  = 4;
    localparam int IdW   = 5;

    typedef struct packed {
        logic [IdxW-1:0]         robot_index;
        logic [IdxW-1:0]         task_index;
        logic signed [CostW-1:0] entry_cost;
        logic                    load_done;
    } t_in_item;

    typedef struct packed {
        logic [IdW-1:0]          won_robot;
        logic [IdW-1:0]          won_task;
        logic signed [CostW-1:0] won_cost;
        logic                    final_pair;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;      // reopen masks, latch size
        logic clr_scan;   // reset scan index and best
        logic scan;       // one element per cycle
        logic pick_turn;  // take best of turn robot as target
        logic fix_turn;   // advance turn to next open robot
        logic cont_init;  // begin contender sweep
        logic cont_best;  // record candidate's best task
        logic cont_cmp;   // compare candidate against winner, step to next
        logic commit;     // close winner and task, form result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic turn_open;
        logic cand_open;
        logic cand_last;
        logic last_pair;
    } t_sts;
endpackage
`default_nettype wire

// File: rtl/core/gcta_datapath.sv
// matrix memory, open masks and sequential search datapath
`default_nettype none
module gcta_datapath
    import gcta_pkg::*;
#(
    parameter int MAX_AGENTS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire t_in_item        i_wr_item,
    input  wire logic [IdW-1:0]  i_size,
    input  wire t_cmd            i_cmd,
    output t_sts                 o_sts,
    output t_out_item            o_result
);
    localparam int AW = $clog2(MAX_AGENTS);
    localparam int CW = $clog2(MAX_AGENTS + 1);
    localparam int MemDepth = 2 ** (2 * AW);

    logic [CostW-1:0] r_mem [MemDepth];
    logic [CostW-1:0] r_rd;

    logic [MAX_AGENTS-1:0] r_robot_open, r_task_open;
    logic [CW-1:0] r_n;
    logic [AW-1:0] r_turn, r_cand, r_scan, r_scan_d;
    logic          r_scan_vld, r_found, r_cphase;
    logic [AW-1:0] r_best;
    logic [CostW-1:0] r_bkey;
    logic [AW-1:0] r_tgt, r_win;
    logic [CostW-1:0] r_wkey;
    logic [AW-1:0] r_cbt;
    logic [AW-1:0] rd_row, rd_col;
    logic          wr_ok, cand_ok;
    logic [CW-1:0] sz;
    logic [AW-1:0] turn_nx;

    always_comb begin
        if (i_size == '0) sz = CW'(1);
        else if (32'(i_size) > MAX_AGENTS) sz = CW'(MAX_AGENTS);
        else sz = CW'(i_size);
    end

    assign wr_ok = (32'(i_wr_item.robot_index) < MAX_AGENTS)
                && (32'(i_wr_item.task_index) < MAX_AGENTS);
    // turn robot row first, candidate rows during the contender sweep
    assign rd_row = r_cphase ? r_cand : r_turn;
    assign rd_col = (i_cmd.cont_best) ? r_tgt : r_scan;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok)
            r_mem[{AW'(i_wr_item.robot_index), AW'(i_wr_item.task_index)}]
                <= i_wr_item.entry_cost;
        r_rd <= r_mem[{rd_row, rd_col}] ^ {1'b1, {(CostW-1){1'b0}}};
    end

    assign turn_nx = (CW'(r_turn) + 1'b1 < r_n) ? r_turn + 1'b1 : '0;
    assign cand_ok = r_robot_open[r_cand] && (r_cand != r_turn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_open <= '1;
            r_task_open  <= '1;
            r_n          <= CW'(1);
            r_turn       <= '0;
            r_scan_vld   <= 1'b0;
            r_cphase     <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_robot_open <= '1;
                r_task_open  <= '1;
                r_n          <= sz;
            end else if (i_cmd.commit) begin
                r_robot_open[r_win] <= 1'b0;
                r_task_open[r_tgt]  <= 1'b0;
            end
            if (i_cmd.start) r_turn <= '0;
            else if (i_cmd.fix_turn || i_cmd.commit) r_turn <= turn_nx;
            if (i_cmd.cont_init) r_cphase <= 1'b1;
            else if (i_cmd.start || i_cmd.commit) r_cphase <= 1'b0;
            if (i_cmd.clr_scan) begin
                r_scan     <= '0;
                r_scan_vld <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan) begin
                // address stage, then compare on registered read
                r_scan_d   <= r_scan;
                r_scan_vld <= 1'b1;
                if (CW'(r_scan) + 1'b1 < r_n) r_scan <= r_scan + 1'b1;
                if (r_scan_vld && r_task_open[r_scan_d]
                        && (!r_found || r_rd < r_bkey)) begin
                    r_found <= 1'b1;
                    r_best  <= r_scan_d;
                    r_bkey  <= r_rd;
                end
            end
            if (i_cmd.pick_turn) r_tgt <= r_best;
            if (i_cmd.pick_turn) begin
                r_win  <= r_turn;
                r_wkey <= r_bkey;
            end else if (i_cmd.cont_cmp && cand_ok && r_cbt == r_tgt && r_rd < r_wkey) begin
                // r_rd holds candidate's cost at target, read during cont_best
                r_win  <= r_cand;
                r_wkey <= r_rd;
            end
            if (i_cmd.cont_best) r_cbt <= r_best;
            if (i_cmd.cont_init) r_cand <= '0;
            else if (i_cmd.cont_cmp && CW'(r_cand) + 1'b1 < r_n) r_cand <= r_cand + 1'b1;
        end
    end

    always_comb begin
        logic [MAX_AGENTS-1:0] left;
        logic [MAX_AGENTS-1:0] used;
        left = r_robot_open;
        left[r_win] = 1'b0;
        for (int i = 0; i < MAX_AGENTS; i++) used[i] = (CW'(i) < r_n);
        o_result.won_robot  = IdW'(r_win) + 1'b1;
        o_result.won_task   = IdW'(r_tgt) + 1'b1;
        o_result.won_cost   = r_wkey ^ {1'b1, {(CostW-1){1'b0}}};
        o_result.final_pair = ((left & used) == '0);
        o_sts.scan_last = r_scan_vld && (CW'(r_scan_d) + 1'b1 >= r_n)
                       && (CW'(r_scan) + 1'b1 >= r_n);
        o_sts.turn_open = r_robot_open[r_turn];
        o_sts.cand_open = cand_ok;
        o_sts.cand_last = (CW'(r_cand) + 1'b1 >= r_n);
        o_sts.last_pair = ((left & used) == '0);
    end
endmodule
`default_nettype wire

// File: rtl/core/gcta_ctrl.sv
// solve sequencer for the task assigner
`default_nettype none
module gcta_ctrl
    import gcta_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_go,
    input  wire logic i_next,
    input  wire logic i_out_free,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy,
    output logic      o_load,
    output logic      o_emit
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TURN  = 4'd1;
    localparam logic [3:0] S_TSCAN = 4'd2;
    localparam logic [3:0] S_CSEL  = 4'd3;
    localparam logic [3:0] S_CSCAN = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CCMP  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_CNEXT = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [3:0] r_st, n_st;

    assign o_busy = (r_st != S_IDLE) && (r_st != S_WAIT);
    assign o_load = (r_st == S_IDLE);

    always_comb begin
        o_cmd  = '0;
        o_emit = 1'b0;
        n_st   = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.start = 1'b1;
                    n_st = S_TURN;
                end
            end
            S_WAIT: begin
                // each transfer during a solve releases the next pair
                if (i_next) n_st = S_TURN;
            end
            S_TURN: begin
                if (i_sts.turn_open) begin
                    o_cmd.clr_scan = 1'b1;
                    n_st = S_TSCAN;
                end else o_cmd.fix_turn = 1'b1;
            end
            S_TSCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_st = S_CSEL;
                end
            end
            S_CSEL: begin
                o_cmd.pick_turn = 1'b1;
                o_cmd.cont_init = 1'b1;
                o_cmd.clr_scan  = 1'b1;
                n_st = S_CNEXT;
            end
            S_CNEXT: begin
                if (i_sts.cand_open) begin
                    o_cmd.clr_scan = 1'b1;
                    n_st = S_CSCAN;
                end else if (i_sts.cand_last) n_st = S_EMIT;
                else begin
                    // closed or turn robot: step past it
                    o_cmd.cont_cmp = 1'b1;
                end
            end
            S_CSCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_st = S_CRD;
            end
            S_CRD: begin
                o_cmd.cont_best = 1'b1;
                n_st = S_CCMP;
            end
            S_CCMP: begin
                o_cmd.cont_cmp = 1'b1;
                n_st = S_EMIT;
                if (!i_sts.cand_last) n_st = S_CNEXT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    o_emit = 1'b1;
                    n_st = i_sts.last_pair ? S_IDLE : S_WAIT;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/greedy_contention_task_assigner_core.sv
// channel   | dir | payload    | handshake
// in        | in  | t_in_item  | i_in_valid / o_in_stall
// out       | out | t_out_item | o_out_valid / i_out_stall
// cfg       | in  | robot_count| apb psel/penable/pwrite
// entries load one per cycle; the entry with load_done starts a solve and brings the first pair.
// each later input transfer of a solve is dropped and brings the next pair.
// a pair scans the row of the turn robot and then the row of every other open robot, its pace
// set by the single read port of the cost memory scanned one entry a cycle.
// input is stalled while a pair is worked out or waits for the output register.
// reset reopens all robots and tasks; the output register holds a pair until it is taken.
`default_nettype none
module greedy_contention_task_assigner_core
    import gcta_pkg::*;
#(
    parameter int MAX_AGENTS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_item,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [0:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    logic [IdW-1:0] r_robot_count;
    logic r_ovld;
    t_out_item r_out;
    t_cmd cmd;
    t_sts sts;
    t_out_item res;
    logic busy, load, emit, acc, go, out_free;

    assign pready = 1'b1;
    assign prdata = {27'd0, r_robot_count};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_robot_count <= IdW'(16);
        else if (psel && penable && pwrite && paddr == 1'b0)
            r_robot_count <= pwdata[IdW-1:0];
    end

    assign o_in_stall = busy;
    assign acc = i_in_valid && !busy;
    assign go = acc && i_in_item.load_done;
    assign out_free = !r_ovld || !i_out_stall;

    gcta_datapath #(.MAX_AGENTS(MAX_AGENTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(acc && load), .i_wr_item(i_in_item), .i_size(r_robot_count),
        .i_cmd(cmd), .o_sts(sts), .o_result(res)
    );

    gcta_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(go), .i_next(acc), .i_out_free(out_free), .i_sts(sts),
        .o_cmd(cmd), .o_busy(busy), .o_load(load), .o_emit(emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            if (emit) r_ovld <= 1'b1;
            else if (!i_out_stall) r_ovld <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) if (emit) r_out <= res;

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire

// File: sim/tb_greedy_contention_task_assigner_core.sv
// self-checking testbench for the greedy contention task assigner core
`default_nettype none
module tb_greedy_contention_task_assigner_core;
    import gcta_pkg::*;

    localparam int NMax = 16;
    localparam int NumItems = 1450;
    localparam int CycleLimit = 3000000;
    localparam logic [0:0] AddrRobotCount = 1'b0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    greedy_contention_task_assigner_core #(.MAX_AGENTS(NMax)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predictor state
    logic signed [CostW-1:0] cost_mem [NMax*NMax];
    bit                      entry_written [NMax*NMax];
    logic [4:0]              robot_count_reg;
    t_out_item               pending_pairs [$];
    t_out_item               solve_pairs [$];

    int  items_sent;
    int  solves_started;
    int  pairs_checked;
    int  mismatches;
    int  cycle_count;
    int  out_hold_cycles;
    bit  out_quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d pairs outstanding", cycle_count,
                     pending_pairs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // cheapest open task of a robot, lowest id on a tie
    function automatic int cheapest_task(int r, int n, logic [NMax-1:0] task_open);
        int best;
        bit found;
        logic signed [CostW-1:0] best_cost;
        best = 0;
        found = 0;
        best_cost = '0;
        for (int j = 0; j < n; j++) begin
            if (task_open[j] && (!found || cost_mem[r*NMax+j] < best_cost)) begin
                best = j;
                best_cost = cost_mem[r*NMax+j];
                found = 1;
            end
        end
        return best;
    endfunction

    // full greedy solve of the n x n matrix, one expected pair per robot
    task automatic predict_assignments(int n);
        logic [NMax-1:0] robot_open;
        logic [NMax-1:0] task_open;
        logic [NMax-1:0] in_use;
        logic signed [CostW-1:0] win_cost;
        int turn;
        int r;
        int bt;
        int wr;
        t_out_item pair;
        robot_open = '1;
        task_open = '1;
        in_use = (n >= NMax) ? '1 : NMax'((32'd1 << n) - 32'd1);
        turn = 1;
        for (int p = 0; p < n; p++) begin
            r = turn - 1;
            if (r >= n) r = 0;
            for (int k = 0; k < n && !robot_open[r]; k++)
                r = (r + 1 < n) ? r + 1 : 0;
            bt = cheapest_task(r, n, task_open);
            wr = r;
            win_cost = cost_mem[r*NMax+bt];
            for (int q = 0; q < n; q++) begin
                if (q != r && robot_open[q] && cheapest_task(q, n, task_open) == bt
                        && cost_mem[q*NMax+bt] < win_cost) begin
                    wr = q;
                    win_cost = cost_mem[q*NMax+bt];
                end
            end
            robot_open[wr] = 1'b0;
            task_open[bt] = 1'b0;
            turn = (r + 1 < n) ? r + 2 : 1;
            pair.won_robot  = IdW'(wr + 1);
            pair.won_task   = IdW'(bt + 1);
            pair.won_cost   = win_cost;
            pair.final_pair = ((robot_open & in_use) == '0);
            solve_pairs.push_back(pair);
        end
    endtask

    function automatic int active_size();
        if (robot_count_reg == 0) return 1;
        if (robot_count_reg > NMax) return NMax;
        return int'(robot_count_reg);
    endfunction

    function automatic bit matrix_ready(int n);
        for (int r = 0; r < n; r++)
            for (int t = 0; t < n; t++)
                if (!entry_written[r*NMax+t]) return 0;
        return 1;
    endfunction

    // output side: random stalls plus an optional long hold-off
    initial begin
        int seg;
        i_out_stall = 1'b0;
        seg = 0;
        forever begin
            @(negedge i_clk);
            if (out_hold_cycles > 0) begin
                i_out_stall = 1'b1;
                out_hold_cycles = out_hold_cycles - 1;
            end else if (out_quiet) begin
                i_out_stall = 1'b0;
            end else if (seg > 0) begin
                seg = seg - 1;
            end else begin
                i_out_stall = ($urandom_range(0, 2) == 0);
                seg = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(0, 3);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pairs.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected pair: robot %0d task %0d cost %h final %b",
                             o_out_item.won_robot, o_out_item.won_task,
                             o_out_item.won_cost, o_out_item.final_pair);
            end else begin
                want = pending_pairs.pop_front();
                pairs_checked = pairs_checked + 1;
                if (o_out_item.won_robot !== want.won_robot
                        || o_out_item.won_task !== want.won_task
                        || o_out_item.won_cost !== want.won_cost
                        || o_out_item.final_pair !== want.final_pair) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("pair mismatch: exp r%0d t%0d c%h f%b, got r%0d t%0d c%h f%b",
                                 want.won_robot, want.won_task, want.won_cost,
                                 want.final_pair, o_out_item.won_robot,
                                 o_out_item.won_task, o_out_item.won_cost,
                                 o_out_item.final_pair);
                end
            end
        end
    end

    // during a solve a transfer is dropped and releases the next pair
    task automatic send_entry(int ri, int ti, logic signed [CostW-1:0] cost, bit done);
        int gap;
        gap = $urandom_range(0, 99);
        if (gap >= 97)      repeat ($urandom_range(40, 120)) @(negedge i_clk);
        else if (gap >= 85) repeat ($urandom_range(1, 4)) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item.robot_index = IdxW'(ri);
        i_in_item.task_index  = IdxW'(ti);
        i_in_item.entry_cost  = cost;
        i_in_item.load_done   = done;
        do @(posedge i_clk); while (o_in_stall);
        items_sent = items_sent + 1;
        if (solve_pairs.size() != 0) begin
            pending_pairs.push_back(solve_pairs.pop_front());
        end else begin
            cost_mem[ri*NMax+ti] = cost;
            entry_written[ri*NMax+ti] = 1'b1;
            if (done) begin
                solves_started = solves_started + 1;
                predict_assignments(active_size());
                pending_pairs.push_back(solve_pairs.pop_front());
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // feed throwaway transfers until the running solve has released every pair
    task automatic finish_solve();
        while (solve_pairs.size() != 0)
            send_entry($urandom_range(0, NMax-1), $urandom_range(0, NMax-1),
                       $urandom, $urandom_range(0, 1) == 1);
    endtask

    task automatic wait_results_drained();
        finish_solve();
        while (pending_pairs.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_robot_count(logic [4:0] value);
        wait_results_drained();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = AddrRobotCount;
        pwdata = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        robot_count_reg = value;
    endtask

    function automatic logic signed [CostW-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return CostW'($urandom_range(0, 3)) - 1;
            3: return CostW'($urandom_range(0, 7)) << 16;
            default: return $urandom;
        endcase
    endfunction

    // one matrix load in random order, partial if the matrix is already full, optional stray entries, then the start
    task automatic load_and_solve(int n, bit stray);
        int order [$];
        int idx;
        int last;
        for (int e = 0; e < n*n; e++) order.push_back(e);
        order.shuffle();
        if (matrix_ready(n) && $urandom_range(0, 2) == 0)
            order = order[0:$urandom_range(0, n*n-1)];
        if (stray)
            repeat ($urandom_range(1, 6))
                send_entry($urandom_range(0, NMax-1), $urandom_range(0, NMax-1),
                           pick_cost(), 1'b0);
        last = order.pop_back();
        foreach (order[i]) begin
            idx = order[i];
            send_entry(idx / n, idx % n, pick_cost(), 1'b0);
        end
        if (stray && $urandom_range(0, 1) == 0) begin
            // the start entry may land outside the active square
            send_entry(last / n, last % n, pick_cost(), 1'b0);
            send_entry($urandom_range(0, NMax-1), $urandom_range(0, NMax-1),
                       pick_cost(), 1'b1);
        end else begin
            send_entry(last / n, last % n, pick_cost(), 1'b1);
        end
        finish_solve();
    endtask

    task automatic test_directed_cases();
        // all costs equal: turn robot keeps every tie
        write_robot_count(5'd2);
        send_entry(0, 0, 32'sd5, 1'b0);
        send_entry(0, 1, 32'sd5, 1'b0);
        send_entry(1, 0, 32'sd5, 1'b0);
        send_entry(1, 1, 32'sd5, 1'b1);
        // extremes and a contender that beats the turn robot
        write_robot_count(5'd3);
        send_entry(0, 0, 32'sh7fff_ffff, 1'b0);
        send_entry(0, 1, 32'sh0001_0000, 1'b0);
        send_entry(0, 2, 32'sh7fff_ffff, 1'b0);
        send_entry(1, 0, 32'sh0000_0000, 1'b0);
        send_entry(1, 1, 32'sh8000_0000, 1'b0);
        send_entry(1, 2, 32'sh0000_0001, 1'b0);
        send_entry(2, 0, 32'shffff_ffff, 1'b0);
        send_entry(2, 1, 32'sh8000_0000, 1'b0);
        send_entry(2, 2, 32'sh8000_0000, 1'b1);
        // size zero is taken as one
        write_robot_count(5'd0);
        send_entry(0, 0, -32'sd7, 1'b1);
        // oversize saturates to the full matrix
        write_robot_count(5'd31);
        load_and_solve(NMax, 1'b0);
    endtask

    task automatic test_output_hold();
        // receiver holds off while the sender keeps offering transfers
        write_robot_count(5'd4);
        out_hold_cycles = 400;
        load_and_solve(4, 1'b0);
        load_and_solve(4, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_solves();
        int n;
        int pick;
        while (items_sent < NumItems) begin
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)       write_robot_count(5'($urandom_range(0, 31)));
                else if (pick < 10) write_robot_count(5'd16);
                else if (pick < 75) write_robot_count(5'($urandom_range(1, 4)));
                else                write_robot_count(5'($urandom_range(5, 8)));
            end
            out_quiet = ($urandom_range(0, 5) == 0);
            n = active_size();
            load_and_solve(n, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) wait_results_drained();
        end
        out_quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        robot_count_reg = 5'd16;
        items_sent = 0;
        solves_started = 0;
        pairs_checked = 0;
        mismatches = 0;
        cycle_count = 0;
        out_hold_cycles = 0;
        out_quiet = 1'b0;
        for (int e = 0; e < NMax*NMax; e++) begin
            cost_mem[e] = '0;
            entry_written[e] = 1'b0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_output_hold();
        test_random_solves();

        wait_results_drained();
        repeat (50) @(negedge i_clk);
        $display("run covered %0d entry transfers, %0d solves, %0d pairs checked",
                 items_sent, solves_started, pairs_checked);
        $display("sizes 1..16 with saturation, ties, extremes and long output hold-off");
        if (mismatches == 0 && pending_pairs.size() == 0 && solve_pairs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d pairs never seen", mismatches,
                     pending_pairs.size() + solve_pairs.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: greedy_contention_task_assigner_core.f
rtl/core/gcta_pkg.sv
rtl/core/gcta_datapath.sv
rtl/core/gcta_ctrl.sv
rtl/core/greedy_contention_task_assigner_core.sv
sim/tb_greedy_contention_task_assigner_core.sv
